// ===== rtl/core/psmf_pkg.sv =====
// ----------------------------------------------------------------------------
// psmf_pkg: shared types and constants of the point self-mask filter
// Body record layout, command and register codes, and the step tables
// of the containment evaluator.
// ----------------------------------------------------------------------------
package psmf_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MaxBodiesDef = 16;
  localparam int unsigned FracBitsDef  = 16;

  // table geometry
  localparam int unsigned WordsPerBody = 16;
  localparam int unsigned Slots        = 16;
  localparam logic [4:0]  NO_HIT       = 5'd16;

  // one body: transform words 0-11, dims 12-14, shape code 15
  typedef logic [WordsPerBody-1:0][31:0] body_rec_t;
  typedef logic [2:0][31:0]              point_t;

  // command codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BODY_COUNT = 2'd0,
    CFG_PADDING    = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_idx_e;

  // shape codes
  localparam logic [31:0] SHAPE_BOX      = 32'd0;
  localparam logic [31:0] SHAPE_SPHERE   = 32'd1;
  localparam logic [31:0] SHAPE_CYLINDER = 32'd2;

  // record word positions
  localparam logic [3:0] DIM_WORD   = 4'd12;
  localparam logic [3:0] SHAPE_WORD = 4'd15;

  // control state of the scan sequencer
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // write port into one cell
  typedef struct packed {
    logic        en;
    logic [3:0]  word;
    logic [31:0] data;
  } cell_wr_t;

  // evaluator answer
  typedef struct packed {
    logic done;
    logic hit;
  } eval_res_t;

  // evaluator step plan: 9 transform products, 3 dimension products,
  // 12 square partial products, one drain step and one decision step
  localparam logic [4:0] DIM_FIRST   = 5'd9;
  localparam logic [4:0] SQ_FIRST    = 5'd12;
  localparam logic [4:0] ISSUE_END   = 5'd24;
  localparam logic [4:0] DECIDE_STEP = 5'd25;

  localparam logic [3:0] XF_WORD [9] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
                                         4'd8, 4'd9, 4'd10};
  localparam logic [1:0] XF_COL  [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                         2'd0, 2'd1, 2'd2};
  localparam logic [1:0] XF_ROW  [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                         2'd2, 2'd2, 2'd2};

  // square source: 0-2 local coordinate, 3 radius
  localparam logic [1:0] SQ_SRC  [12] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                          2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
  // partial product: 0 low*low, 1 low*high, 2 high*high
  localparam logic [1:0] SQ_PART [12] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                          2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] SRC_RADIUS = 2'd3;
  localparam logic [1:0] PART_LL    = 2'd0;
  localparam logic [1:0] PART_LH    = 2'd1;

endpackage

// ===== rtl/core/psmf_cell.sv =====
// ----------------------------------------------------------------------------
// psmf_cell: one body slot of the rotating table
// Holds the 16 words of one body, takes a single-word load, and passes
// its record to the neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module psmf_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  psmf_pkg::cell_wr_t  wr_i,
  input  psmf_pkg::body_rec_t rec_i,
  output psmf_pkg::body_rec_t rec_o
);
  import psmf_pkg::*;

  body_rec_t rec_q;

  // word load has priority; loads only arrive while the ring is parked
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rec_q[wr_i.word] <= wr_i.data;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== rtl/core/psmf_eval.sv =====
// ----------------------------------------------------------------------------
// psmf_eval: containment test of one point against the head body
// A single 33x33 multiplier is stepped through the transform, the scaled
// dimensions and the split squares; the decision follows the last product.
// ----------------------------------------------------------------------------
module psmf_eval #(
  parameter int unsigned FRAC_BITS = psmf_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  psmf_pkg::body_rec_t rec_i,
  input  psmf_pkg::point_t    point_i,
  input  logic [23:0]         scale_i,
  input  logic [30:0]         pad_i,
  output psmf_pkg::eval_res_t res_o
);
  import psmf_pkg::*;

  // local coordinate width and square accumulator width
  localparam int unsigned LW  = 65 - FRAC_BITS;
  localparam int unsigned DPW = 57;
  localparam int unsigned SQW = 130 - 2 * FRAC_BITS;

  logic                  active_q;
  logic [4:0]            s_q;
  logic                  tag_vld_q;
  logic [4:0]            tag_q;
  logic signed [65:0]    prod_q;
  logic signed [32:0]    op_a;
  logic signed [32:0]    op_b;

  logic signed [LW-1:0]  loc_q [3];
  logic signed [DPW-1:0] dprod_q [3];
  logic [SQW-1:0]        nxy_q;
  logic [SQW-1:0]        nz_q;
  logic [SQW-1:0]        rr_q;

  logic [LW-1:0]         loc_mag [3];
  logic signed [LW-1:0]  rad;
  logic [LW-1:0]         rad_mag;
  logic signed [LW-1:0]  half [3];
  logic                  hit;

  function automatic logic [LW-1:0] mag_of(input logic signed [LW-1:0] v);
    return v[LW-1] ? LW'(-v) : LW'(v);
  endfunction

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      s_q       <= '0;
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= active_q && (s_q < ISSUE_END);
      if (go_i) begin
        active_q <= 1'b1;
        s_q      <= '0;
      end else if (active_q) begin
        if (s_q == DECIDE_STEP) begin
          active_q <= 1'b0;
        end else begin
          s_q <= s_q + 5'd1;
        end
      end
    end
  end

  // magnitudes and scaled dimensions
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      loc_mag[k] = mag_of(loc_q[k]);
      half[k]    = LW'(dprod_q[k] >>> (FRAC_BITS + 1)) + LW'(pad_i);
    end
    rad     = LW'(dprod_q[0] >>> FRAC_BITS) + LW'(pad_i);
    rad_mag = mag_of(rad);
  end

  // multiplier operand selection
  always_comb begin
    logic [3:0]    sidx;
    logic [1:0]    dk;
    logic [LW-1:0] m;
    logic [31:0]   w;
    sidx = 4'(s_q - SQ_FIRST);
    dk   = 2'(s_q - DIM_FIRST);
    m    = '0;
    w    = '0;
    op_a = '0;
    op_b = '0;
    if (s_q < DIM_FIRST) begin
      w    = rec_i[XF_WORD[s_q[3:0]]];
      op_a = {w[31], w};
      op_b = {point_i[XF_COL[s_q[3:0]]][31], point_i[XF_COL[s_q[3:0]]]};
    end else if (s_q < SQ_FIRST) begin
      w    = rec_i[DIM_WORD + {2'b00, dk}];
      op_a = {w[31], w};
      op_b = {9'd0, scale_i};
    end else if (s_q < ISSUE_END) begin
      m = (SQ_SRC[sidx] == SRC_RADIUS) ? rad_mag : loc_mag[SQ_SRC[sidx]];
      case (SQ_PART[sidx])
        PART_LL: begin
          op_a = {1'b0, m[31:0]};
          op_b = {1'b0, m[31:0]};
        end
        PART_LH: begin
          op_a = {1'b0, m[31:0]};
          op_b = 33'(m[LW-1:32]);
        end
        default: begin
          op_a = 33'(m[LW-1:32]);
          op_b = 33'(m[LW-1:32]);
        end
      endcase
    end
  end

  // product register and accumulation, in the step after issue
  always_ff @(posedge clk_i) begin
    logic [3:0]     sidx;
    logic [SQW-1:0] term;
    sidx   = 4'(tag_q - SQ_FIRST);
    term   = '0;
    prod_q <= op_a * op_b;
    tag_q  <= s_q;
    if (go_i) begin
      for (int k = 0; k < 3; k++) begin
        loc_q[k] <= LW'(signed'(rec_i[4*k+3]));
      end
      nxy_q <= '0;
      nz_q  <= '0;
      rr_q  <= '0;
    end else if (tag_vld_q) begin
      if (tag_q < DIM_FIRST) begin
        loc_q[XF_ROW[tag_q[3:0]]] <= loc_q[XF_ROW[tag_q[3:0]]]
                                     + LW'(prod_q >>> FRAC_BITS);
      end else if (tag_q < SQ_FIRST) begin
        dprod_q[2'(tag_q - DIM_FIRST)] <= DPW'(prod_q);
      end else begin
        case (SQ_PART[sidx])
          PART_LL: term = SQW'(prod_q[63:0]);
          PART_LH: term = SQW'(prod_q[63:0]) << 33;
          default: term = SQW'(prod_q[63:0]) << 64;
        endcase
        case (SQ_SRC[sidx])
          2'd0, 2'd1: nxy_q <= nxy_q + term;
          2'd2:       nz_q  <= nz_q + term;
          default:    rr_q  <= rr_q + term;
        endcase
      end
    end
  end

  // containment decision by shape
  always_comb begin
    logic [SQW:0] nsum;
    logic         box_in;
    nsum   = {1'b0, nxy_q} + {1'b0, nz_q};
    box_in = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (half[k][LW-1] || (loc_mag[k] > $unsigned(half[k]))) begin
        box_in = 1'b0;
      end
    end
    if (rec_i[SHAPE_WORD] == SHAPE_BOX) begin
      hit = box_in;
    end else if (rec_i[SHAPE_WORD] == SHAPE_SPHERE) begin
      hit = nsum <= {1'b0, rr_q};
    end else if (rec_i[SHAPE_WORD] == SHAPE_CYLINDER) begin
      hit = (nxy_q <= rr_q) && !half[1][LW-1] && (loc_mag[2] <= $unsigned(half[1]));
    end else begin
      hit = 1'b0;
    end
  end

  assign res_o.done = active_q && (s_q == DECIDE_STEP);
  assign res_o.hit  = hit;

endmodule

// ===== rtl/core/point_self_mask_filter.sv =====
// ----------------------------------------------------------------------------
// point_self_mask_filter: robot self-filter for depth points
// Body table in a rotating ring of cells with one shared containment unit.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. action_i = 0
//   writes one table word (body_index_i, word_index_i, word_value_i) in that
//   cycle and gives no result; loads to bodies beyond MAX_BODIES are dropped.
//   action_i = 1 tests a point; busy stays high until the answer is out.
//   The answer (keep_o, hit_body_o) shows for one cycle with valid_o; the
//   receiver cannot stall it.
//   A test checks the bodies one at a time, up to and including the first
//   hit, on the single multiplier of the evaluator; every other slot is
//   just rotated past. The ring always makes a full turn so the table is
//   back in place. Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is to be
//   written by the user while idle; the block itself does not enforce this.
//   Reset clears control and sets body_count 0, padding 0, scale 1.0; the
//   body table holds garbage until loaded.
// ----------------------------------------------------------------------------
module point_self_mask_filter #(
  parameter int unsigned MAX_BODIES = psmf_pkg::MaxBodiesDef,
  parameter int unsigned FRAC_BITS  = psmf_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [3:0]  body_index_i,
  input  logic [3:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic        point_finite_i,
  output logic        valid_o,
  output logic        keep_o,
  output logic [4:0]  hit_body_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);
  import psmf_pkg::*;

  localparam int unsigned CW   = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned NLIM = (MAX_BODIES < Slots) ? MAX_BODIES : Slots;

  state_e      state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] hit_q, hit_d;
  logic        started_q, started_d;
  logic        found_q, found_d;
  logic        valid_q, valid_d;
  logic        keep_q, keep_d;
  logic [4:0]  hitb_q, hitb_d;

  logic [4:0]  body_count_q;
  logic [30:0] padding_q;
  logic [23:0] scale_q;

  point_t      pt_q;
  logic        fin_q;
  logic [4:0]  n_q;
  logic [4:0]  n_eff;

  logic        accept;
  logic        rotate;
  logic        eval_go;
  eval_res_t   eval_res;
  body_rec_t   ring [MAX_BODIES];

  assign accept = start && !busy;
  assign n_eff  = (body_count_q > 5'(NLIM)) ? 5'(NLIM) : body_count_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_count_q <= '0;
      padding_q    <= '0;
      scale_q      <= 24'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BODY_COUNT: body_count_q <= cfg_wdata_i[4:0];
        CFG_PADDING:    padding_q    <= cfg_wdata_i;
        CFG_SCALE:      scale_q      <= cfg_wdata_i[23:0];
        default:        ;
      endcase
    end
  end

  // latch the point on a test transfer
  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ACT_TEST)) begin
      pt_q  <= {point_z_i, point_y_i, point_x_i};
      fin_q <= point_finite_i;
      n_q   <= n_eff;
    end
  end

  // ring of body cells, head at slot zero
  for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
    cell_wr_t wr;
    assign wr.en   = accept && (action_i == ACT_LOAD)
                     && (7'(body_index_i) == 7'(k));
    assign wr.word = word_index_i;
    assign wr.data = word_value_i;

    psmf_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (rotate),
      .wr_i    (wr),
      .rec_i   (ring[(k + 1) % MAX_BODIES]),
      .rec_o   (ring[k])
    );
  end

  psmf_eval #(
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (eval_go),
    .rec_i   (ring[0]),
    .point_i (pt_q),
    .scale_i (scale_q),
    .pad_i   (padding_q),
    .res_o   (eval_res)
  );

  // control state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      hit_q     <= '0;
      started_q <= 1'b0;
      found_q   <= 1'b0;
      valid_q   <= 1'b0;
      keep_q    <= 1'b1;
      hitb_q    <= NO_HIT;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      hit_q     <= hit_d;
      started_q <= started_d;
      found_q   <= found_d;
      valid_q   <= valid_d;
      keep_q    <= keep_d;
      hitb_q    <= hitb_d;
    end
  end

  // scan sequencing over the ring
  always_comb begin
    logic skip;
    logic slot_done;
    skip      = 1'b0;
    slot_done = 1'b0;
    state_d   = state_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    started_d = started_q;
    found_d   = found_q;
    valid_d   = 1'b0;
    keep_d    = keep_q;
    hitb_d    = hitb_q;
    rotate    = 1'b0;
    eval_go   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_TEST)) begin
          state_d   = ST_SCAN;
          cnt_d     = '0;
          found_d   = 1'b0;
          started_d = 1'b0;
        end
      end
      ST_SCAN: begin
        skip = found_q || !fin_q || !(7'(cnt_q) < 7'(n_q));
        if (skip) begin
          slot_done = 1'b1;
        end else if (!started_q) begin
          eval_go   = 1'b1;
          started_d = 1'b1;
        end else if (eval_res.done) begin
          slot_done = 1'b1;
          started_d = 1'b0;
          if (eval_res.hit) begin
            found_d = 1'b1;
            hit_d   = cnt_q;
          end
        end
        if (slot_done) begin
          rotate = 1'b1;
          if (cnt_q == CW'(MAX_BODIES - 1)) begin
            state_d = ST_IDLE;
            valid_d = 1'b1;
            keep_d  = !found_d;
            hitb_d  = found_d ? 5'(hit_d) : NO_HIT;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy       = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign keep_o     = keep_q;
  assign hit_body_o = hitb_q;

  // a test transfer always starts a scan
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_TEST)) |=> busy)
    else $error("test transfer did not start a scan");

  // the answer appears only once the scan has let go
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while still scanning");

  // keep and hit index agree
  a_keep_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (keep_o == (hit_body_o == NO_HIT)))
    else $error("keep and hit body disagree");

  // evaluator only runs during a scan
  a_go_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_res.done |-> (state_q == ST_SCAN) && started_q)
    else $error("evaluator finished outside a scan");

endmodule
